// ===== rtl/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

  // Command codes carried in the op field of a command beat.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Item kinds.
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Register reset and bit constants.
  localparam logic [7:0] PHASE_TICKS_RESET = 8'd60;
  localparam int unsigned MSB_BIT = 7;

  // Phase numbers of the byte commands.
  localparam logic [4:0] PH_BITS_END   = 5'd16;
  localparam logic [4:0] PH_ACK_SETUP  = 5'd17;
  localparam logic [4:0] PH_ACK_HIGH   = 5'd18;
  localparam logic [4:0] PH_TOTAL_START = 5'd3;
  localparam logic [4:0] PH_TOTAL_STOP  = 5'd2;
  localparam logic [4:0] PH_TOTAL_BYTE  = 5'd20;

  // One input beat.
  typedef struct packed {
    logic       kind;
    logic [1:0] op;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
    logic       rejected;
  } res_t;

endpackage

// ===== rtl/i2cmbe_core.sv =====
module i2cmbe_core
  import i2cmbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  item_t      item,
  input  logic [7:0] phase_ticks,
  output res_t       res
);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shb;
  } pins_t;

  logic [4:0] phase_index_r, phase_index_nxt;
  logic [7:0] tick_count_r, tick_count_nxt;
  logic [7:0] shift_byte_r, shift_byte_nxt;
  op_t        current_op_r, current_op_nxt;
  logic       ack_choice_r, ack_choice_nxt;
  logic       scl_level_r, scl_level_nxt;
  logic       sda_level_r, sda_level_nxt;
  logic       active_r, active_nxt;
  logic       ack_missing_r, ack_missing_nxt;
  logic [7:0] read_hold_r, read_hold_nxt;

  // Pin action taken at the start of a phase.
  function automatic pins_t apply_phase(op_t op, logic [4:0] idx, logic [7:0] shb,
                                        logic ackc, logic scl, logic sda);
    pins_t p;
    p.scl = scl;
    p.sda = sda;
    p.shb = shb;
    case (op)
      OP_START: begin
        if (idx == 5'd0) begin
          p.sda = 1'b1;
          p.scl = 1'b1;
        end else if (idx == 5'd1) begin
          p.sda = 1'b0;
        end else begin
          p.scl = 1'b0;
        end
      end
      OP_STOP: begin
        if (idx == 5'd0) begin
          p.sda = 1'b0;
          p.scl = 1'b1;
        end else begin
          p.sda = 1'b1;
        end
      end
      OP_WRITE: begin
        if (idx < PH_BITS_END) begin
          if (!idx[0]) begin
            p.scl = 1'b0;
          end else begin
            p.sda = shb[MSB_BIT];
            p.shb = {shb[6:0], 1'b0};
            p.scl = 1'b1;
          end
        end else if (idx == PH_BITS_END) begin
          p.scl = 1'b0;
        end else if (idx == PH_ACK_SETUP) begin
          p.scl = 1'b0;
          p.sda = 1'b1;
        end else if (idx == PH_ACK_HIGH) begin
          p.scl = 1'b1;
        end else begin
          p.scl = 1'b0;
        end
      end
      default: begin
        if (idx == 5'd0) p.sda = 1'b1;
        if (idx < PH_BITS_END) begin
          p.scl = idx[0];
        end else if (idx == PH_BITS_END) begin
          p.scl = 1'b0;
        end else if (idx == PH_ACK_SETUP) begin
          p.sda = !ackc;
        end else if (idx == PH_ACK_HIGH) begin
          p.scl = 1'b1;
        end else begin
          p.scl = 1'b0;
        end
      end
    endcase
    return p;
  endfunction

  // Number of phases in each command.
  function automatic logic [4:0] phase_total(op_t op);
    logic [4:0] t;
    case (op)
      OP_START: t = PH_TOTAL_START;
      OP_STOP:  t = PH_TOTAL_STOP;
      default:  t = PH_TOTAL_BYTE;
    endcase
    return t;
  endfunction

  // Next state and result for the beat in the input register.
  always_comb begin
    logic [7:0] limit;
    logic [7:0] tick_inc;
    logic [4:0] ph_inc;
    logic [7:0] shb_mid;
    op_t        cmd_op;
    pins_t      p;
    phase_index_nxt = phase_index_r;
    tick_count_nxt  = tick_count_r;
    shift_byte_nxt  = shift_byte_r;
    current_op_nxt  = current_op_r;
    ack_choice_nxt  = ack_choice_r;
    scl_level_nxt   = scl_level_r;
    sda_level_nxt   = sda_level_r;
    active_nxt      = active_r;
    ack_missing_nxt = ack_missing_r;
    read_hold_nxt   = read_hold_r;
    res.done_res    = 1'b0;
    res.rejected    = 1'b0;
    limit    = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    tick_inc = tick_count_r + 8'd1;
    ph_inc   = phase_index_r + 5'd1;
    cmd_op   = op_t'(item.op);
    shb_mid  = shift_byte_r;
    p        = '0;

    if (item.kind == KIND_CMD) begin
      if (active_r) begin
        res.rejected = 1'b1;
      end else begin
        current_op_nxt  = cmd_op;
        phase_index_nxt = 5'd0;
        tick_count_nxt  = 8'd0;
        active_nxt      = 1'b1;
        if (cmd_op == OP_WRITE) begin
          shb_mid         = item.write_data;
          ack_missing_nxt = 1'b0;
        end else begin
          shb_mid = 8'd0;
        end
        if (cmd_op == OP_READ) ack_choice_nxt = item.send_ack;
        p = apply_phase(cmd_op, 5'd0, shb_mid, ack_choice_nxt, scl_level_r, sda_level_r);
        scl_level_nxt  = p.scl;
        sda_level_nxt  = p.sda;
        shift_byte_nxt = p.shb;
      end
    end else if (active_r) begin
      tick_count_nxt = tick_inc;
      if (tick_inc >= limit) begin
        // Phase ends: take the SDA sample, then move to the next phase.
        if (current_op_r == OP_WRITE && phase_index_r == PH_ACK_HIGH) begin
          ack_missing_nxt = item.sda_in;
        end
        if (current_op_r == OP_READ && phase_index_r < PH_BITS_END && phase_index_r[0]) begin
          shb_mid = {shift_byte_r[6:0], item.sda_in};
        end
        tick_count_nxt = 8'd0;
        shift_byte_nxt = shb_mid;
        if (ph_inc >= phase_total(current_op_r)) begin
          if (current_op_r == OP_READ) read_hold_nxt = shb_mid;
          active_nxt      = 1'b0;
          phase_index_nxt = 5'd0;
          res.done_res    = 1'b1;
        end else begin
          phase_index_nxt = ph_inc;
          p = apply_phase(current_op_r, ph_inc, shb_mid, ack_choice_r,
                          scl_level_r, sda_level_r);
          scl_level_nxt  = p.scl;
          sda_level_nxt  = p.sda;
          shift_byte_nxt = p.shb;
        end
      end
    end

    res.scl_out   = scl_level_nxt;
    res.sda_out   = sda_level_nxt;
    res.busy_res  = active_nxt;
    res.read_data = read_hold_nxt;
    res.no_ack    = ack_missing_nxt;
  end

  // State registers, updated once per processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_index_r <= 5'd0;
      tick_count_r  <= 8'd0;
      shift_byte_r  <= 8'd0;
      current_op_r  <= OP_START;
      ack_choice_r  <= 1'b0;
      scl_level_r   <= 1'b1;
      sda_level_r   <= 1'b1;
      active_r      <= 1'b0;
      ack_missing_r <= 1'b0;
      read_hold_r   <= 8'd0;
    end else if (step) begin
      phase_index_r <= phase_index_nxt;
      tick_count_r  <= tick_count_nxt;
      shift_byte_r  <= shift_byte_nxt;
      current_op_r  <= current_op_nxt;
      ack_choice_r  <= ack_choice_nxt;
      scl_level_r   <= scl_level_nxt;
      sda_level_r   <= sda_level_nxt;
      active_r      <= active_nxt;
      ack_missing_r <= ack_missing_nxt;
      read_hold_r   <= read_hold_nxt;
    end
  end

  // The phase counter stays below the longest command.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_index_r < PH_TOTAL_BYTE) else $error("phase index out of range");

  // An idle engine always rests at phase zero.
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> phase_index_r == 5'd0) else $error("idle with nonzero phase");

  // A finished read publishes its assembled byte on the next cycle.
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res && current_op_r == OP_READ |=> read_hold_r == $past(shift_byte_nxt))
    else $error("read byte not captured");

endmodule

// ===== rtl/i2c_master_byte_engine_unit.sv =====
// I2C master byte engine. Command beats start a start condition, a stop
// condition, a byte write with acknowledge check, or a byte read that ends
// with ACK or NACK; tick beats advance time and carry the sampled SDA level.
// Every pin phase lasts cfg_data ticks (0 behaves as 1, reset 60). Each input
// beat gives exactly one result beat with the pin drives and status after it.
// A beat passes an input register and a result register before its result
// appears on the output, and one beat is taken every cycle while the result
// side does not stall. A command that arrives while busy is flagged as
// rejected and otherwise ignored. Write cfg_data only while the block is
// idle.
module i2c_master_byte_engine_unit
  import i2cmbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [1:0] in_op,
  input  logic [7:0] in_write_data,
  input  logic       in_send_ack,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_data,
  output logic       out_no_ack,
  output logic       out_rejected
);

  logic [7:0] phase_ticks_r;
  logic       in_vld_r, in_vld_nxt;
  item_t      in_item_r;
  logic       out_vld_r, out_vld_nxt;
  res_t       out_res_r;
  res_t       core_res;
  logic       in_acc;
  logic       adv;

  // Configuration register write.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks_r <= cfg_data;
    end
  end

  // Handshake: the held beat moves on whenever the result register is free.
  assign adv         = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = in_vld_r && !adv;
  assign in_acc      = in_valid && !in_stall;
  assign in_vld_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_stall ? out_vld_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.kind       <= in_kind;
      in_item_r.op         <= in_op;
      in_item_r.write_data <= in_write_data;
      in_item_r.send_ack   <= in_send_ack;
      in_item_r.sda_in     <= in_sda_in;
    end
  end

  i2cmbe_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .item        (in_item_r),
    .phase_ticks (phase_ticks_r),
    .res         (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (adv) out_res_r <= core_res;
  end

  assign out_valid     = out_vld_r;
  assign out_scl_out   = out_res_r.scl_out;
  assign out_sda_out   = out_res_r.sda_out;
  assign out_busy_res  = out_res_r.busy_res;
  assign out_done_res  = out_res_r.done_res;
  assign out_read_data = out_res_r.read_data;
  assign out_no_ack    = out_res_r.no_ack;
  assign out_rejected  = out_res_r.rejected;

  // A finishing beat leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res) else $error("done while busy");

  // A rejected command only happens while a command is running.
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res && !out_done_res)
    else $error("rejection while idle");

  // The input side is held back only when a beat is waiting in the register.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall) else $error("spurious stall");

endmodule
